### design/polygon_area_stats_top_assert.svh
// Assertion macros for polygon_area_stats_top.
`ifndef POLYGON_AREA_STATS_TOP_ASSERT_SVH
`define POLYGON_AREA_STATS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define PAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("polygon_area_stats_top: assertion failed");

`define PAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("polygon_area_stats_top: assertion failed");

`else

`define PAS_ASSERT_NOW(label, ante, cons)
`define PAS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### design/pas_pkg.sv
package pas_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int MAX_VERTICES = 256;
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int RECT_VERTICES = 4;

  localparam int PROD_W  = 2 * COORD_WIDTH;
  localparam int TERM_W  = PROD_W + 1;
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int SQ_W    = 2 * COORD_WIDTH;
  localparam int DIST_W  = SQ_W + 1;
  localparam int CROSS_W = 41;
  localparam int AREA_W  = 41;
  localparam int AGG_W   = 48;
  localparam int PCNT_W  = 16;

  localparam int MODE_W     = 4;
  localparam int TARGET_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam int IN_TDATA_W  = 2 * COORD_WIDTH;
  localparam int RES_W       = AREA_W + CNT_W + 1 + 1 + AGG_W + PCNT_W + 1;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int PAD_W       = OUT_TDATA_W - RES_W;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 1'd1;

  localparam logic [MODE_W-1:0] MODE_SUM_EVEN   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SUM_ODD    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SUM_ALL    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SUM_TARGET = 4'd3;
  localparam logic [MODE_W-1:0] MODE_MAX_AREA   = 4'd4;
  localparam logic [MODE_W-1:0] MODE_MIN_AREA   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_MAX_VERT   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_MIN_VERT   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_CNT_EVEN   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_CNT_ODD    = 4'd9;
  localparam logic [MODE_W-1:0] MODE_CNT_TARGET = 4'd10;
  localparam logic [MODE_W-1:0] MODE_CNT_RECT   = 4'd11;

  localparam logic [MODE_W-1:0]   QUERY_MODE_RESET = MODE_SUM_ALL;
  localparam logic [TARGET_W-1:0] TARGET_RESET     = 9'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_SUM,
    KIND_MAX,
    KIND_MIN,
    KIND_COUNT
  } agg_kind_t;

  // products and squared differences of one vertex
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              clear;
    logic              pos0;
    logic              pos1;
    logic              pos2;
    logic              pos3;
    logic [CNT_W-1:0]  cnt;
    logic [PROD_W-1:0] cross_a;
    logic [PROD_W-1:0] cross_b;
    logic [PROD_W-1:0] close_a;
    logic [PROD_W-1:0] close_b;
    logic [SQ_W-1:0]   sq_pc_x;
    logic [SQ_W-1:0]   sq_pc_y;
    logic [SQ_W-1:0]   sq_fc_x;
    logic [SQ_W-1:0]   sq_fc_y;
    logic [SQ_W-1:0]   sq_sc_x;
    logic [SQ_W-1:0]   sq_sc_y;
  } prod_stage_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic              clear;
    logic              is_rect;
    logic [CNT_W-1:0]  cnt;
    logic [AREA_W-1:0] area;
  } area_stage_t;

  typedef struct packed {
    logic [PAD_W-1:0]  pad;
    logic              aggregate_valid;
    logic [PCNT_W-1:0] polygons_seen;
    logic [AGG_W-1:0]  aggregate_value;
    logic              matches_filter;
    logic              is_rect;
    logic [CNT_W-1:0]  vertex_total;
    logic [AREA_W-1:0] twice_area;
  } result_t;

endpackage

### design/polygon_area_stats_top.sv
// Shoelace polygon area with a running aggregate. Vertices stream in one per
// transfer, one per clock at full rate; the last vertex of each polygon carries
// tlast and yields one result transfer. A result appears on m_tvalid once its
// last vertex has passed the five register ranks of the pipe (input, product,
// cross sum, area, result). s_tready falls only while the result register
// holds an untaken result and every rank behind it is full.
// Configuration writes take effect at once, so make them only while no vertex
// or result is left in the pipe.
`include "polygon_area_stats_top_assert.svh"

module polygon_area_stats_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pas_pkg::IN_TDATA_W-1:0]      s_tdata,   // coord_x, coord_y
  input  logic                                s_tlast,   // last_vertex
  input  logic                                s_tuser,   // clear_set
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // twice_area, vertex_total, is_rect, matches_filter, aggregate_value,
  // polygons_seen, aggregate_valid, zero pad
  output logic [pas_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [pas_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pas_pkg::*;

  prod_stage_t prod;
  logic        prod_ready;
  area_stage_t area_st;
  logic        area_ready;
  result_t     res;

  pas_vertex u_vertex (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_x       (s_tdata[COORD_WIDTH-1:0]),
    .in_y       (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .in_last    (s_tlast),
    .in_clear   (s_tuser),
    .prod       (prod),
    .prod_ready (prod_ready)
  );

  pas_cross u_cross (
    .clk        (clk),
    .rst        (rst),
    .prod       (prod),
    .prod_ready (prod_ready),
    .area_st    (area_st),
    .area_ready (area_ready)
  );

  pas_aggregate u_aggregate (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .area_st    (area_st),
    .area_ready (area_ready),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = res;

  `PAS_ASSERT_NOW(a_stall_only_on_held_result, !s_tready, m_tvalid && !m_tready)
  `PAS_ASSERT_NOW(a_rect_has_four, m_tvalid && res.is_rect,
                  res.vertex_total == CNT_W'(RECT_VERTICES))
  `PAS_ASSERT_NEXT(a_result_follows_last, area_st.valid && area_st.last && area_ready,
                   m_tvalid)

endmodule

### design/pas_vertex.sv
module pas_vertex (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic signed [pas_pkg::COORD_WIDTH-1:0]     in_x,
  input  logic signed [pas_pkg::COORD_WIDTH-1:0]     in_y,
  input  logic                                       in_last,
  input  logic                                       in_clear,
  output pas_pkg::prod_stage_t                       prod,
  input  logic                                       prod_ready
);
  import pas_pkg::*;

  function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_WIDTH-1:0] a,
                                              input logic signed [COORD_WIDTH-1:0] b);
    logic signed [DIFF_W-1:0]   d;
    logic signed [2*DIFF_W-1:0] p;
    d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
    p = d * d;
    return p[SQ_W-1:0];
  endfunction

  logic                          v1;
  logic signed [COORD_WIDTH-1:0] x1, y1;
  logic                          last1, clear1;

  logic signed [COORD_WIDTH-1:0] first_x, first_y, second_x, second_y, prev_x, prev_y;
  logic [CNT_W-1:0]              vertex_counter;

  logic                          rdy2, mv1;
  logic                          pos0, pos1, pos2, pos3;
  logic [CNT_W-1:0]              cnt;
  logic signed [COORD_WIDTH-1:0] fx, fy;
  logic signed [PROD_W-1:0]      cross_a, cross_b, close_a, close_b;

  assign rdy2     = !prod.valid || prod_ready;
  assign in_ready = !v1 || rdy2;
  assign mv1      = v1 && rdy2;

  assign pos0 = (vertex_counter == CNT_W'(0));
  assign pos1 = (vertex_counter == CNT_W'(1));
  assign pos2 = (vertex_counter == CNT_W'(2));
  assign pos3 = (vertex_counter == CNT_W'(3));
  assign cnt  = (vertex_counter < CNT_W'(MAX_VERTICES)) ? vertex_counter + CNT_W'(1)
                                                       : CNT_W'(MAX_VERTICES);

  // the first vertex closes against itself
  assign fx = pos0 ? x1 : first_x;
  assign fy = pos0 ? y1 : first_y;

  assign cross_a = prev_x * y1;
  assign cross_b = prev_y * x1;
  assign close_a = x1 * fy;
  assign close_b = fx * y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
    if (in_ready && in_valid) begin
      x1     <= in_x;
      y1     <= in_y;
      last1  <= in_last;
      clear1 <= in_clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x        <= '0;
      first_y        <= '0;
      second_x       <= '0;
      second_y       <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
      vertex_counter <= '0;
    end else if (mv1) begin
      prev_x <= x1;
      prev_y <= y1;
      if (pos0) begin
        first_x <= x1;
        first_y <= y1;
      end
      if (pos1) begin
        second_x <= x1;
        second_y <= y1;
      end
      vertex_counter <= last1 ? '0 : cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod.valid <= 1'b0;
    end else if (rdy2) begin
      prod.valid <= v1;
    end
    if (mv1) begin
      prod.last    <= last1;
      prod.clear   <= clear1;
      prod.pos0    <= pos0;
      prod.pos1    <= pos1;
      prod.pos2    <= pos2;
      prod.pos3    <= pos3;
      prod.cnt     <= cnt;
      prod.cross_a <= cross_a;
      prod.cross_b <= cross_b;
      prod.close_a <= close_a;
      prod.close_b <= close_b;
      prod.sq_pc_x <= sq_diff(prev_x, x1);
      prod.sq_pc_y <= sq_diff(prev_y, y1);
      prod.sq_fc_x <= sq_diff(fx, x1);
      prod.sq_fc_y <= sq_diff(fy, y1);
      prod.sq_sc_x <= sq_diff(second_x, x1);
      prod.sq_sc_y <= sq_diff(second_y, y1);
    end
  end

endmodule

### design/pas_cross.sv
module pas_cross (
  input  logic                  clk,
  input  logic                  rst,
  input  pas_pkg::prod_stage_t  prod,
  output logic                  prod_ready,
  output pas_pkg::area_stage_t  area_st,
  input  logic                  area_ready
);
  import pas_pkg::*;

  localparam int SUM_W = CROSS_W + 1;
  localparam logic [CROSS_W-1:0] CROSS_MAX = {1'b0, {(CROSS_W-1){1'b1}}};
  localparam logic [CROSS_W-1:0] CROSS_MIN = {1'b1, {(CROSS_W-1){1'b0}}};

  logic [DIST_W-1:0]  side0, side1, side2;
  logic [CROSS_W-1:0] cross_sum;

  logic               v3, last3, clear3, rect3;
  logic [CNT_W-1:0]   cnt3;
  logic [CROSS_W-1:0] cross3;
  logic [TERM_W-1:0]  close3;

  logic               rdy4, mv2;
  logic [TERM_W-1:0]  term, close_term;
  logic [DIST_W-1:0]  d_pc, d_fc, d_sc;
  logic [SUM_W-1:0]   acc;
  logic [CROSS_W-1:0] cross_new;
  logic               rect;

  logic [SUM_W-1:0]   c_ext, t_ext, tot, tot_neg;
  logic [AREA_W-1:0]  area;

  assign rdy4       = !area_st.valid || area_ready;
  assign prod_ready = !v3 || rdy4;
  assign mv2        = prod.valid && prod_ready;

  assign term       = {prod.cross_a[PROD_W-1], prod.cross_a}
                    - {prod.cross_b[PROD_W-1], prod.cross_b};
  assign close_term = {prod.close_a[PROD_W-1], prod.close_a}
                    - {prod.close_b[PROD_W-1], prod.close_b};

  assign d_pc = {1'b0, prod.sq_pc_x} + {1'b0, prod.sq_pc_y};
  assign d_fc = {1'b0, prod.sq_fc_x} + {1'b0, prod.sq_fc_y};
  assign d_sc = {1'b0, prod.sq_sc_x} + {1'b0, prod.sq_sc_y};

  always_comb begin
    acc = {cross_sum[CROSS_W-1], cross_sum} + {{(SUM_W-TERM_W){term[TERM_W-1]}}, term};
    if (prod.pos0) begin
      cross_new = '0;
    end else if (acc[SUM_W-1] != acc[SUM_W-2]) begin
      cross_new = acc[SUM_W-1] ? CROSS_MIN : CROSS_MAX;
    end else begin
      cross_new = acc[CROSS_W-1:0];
    end
  end

  assign rect = prod.pos3 && prod.last && (side0 == d_pc) && (side1 == d_fc)
             && (side2 == d_sc);

  always_ff @(posedge clk) begin
    if (rst) begin
      cross_sum <= '0;
      side0     <= '0;
      side1     <= '0;
      side2     <= '0;
    end else if (mv2) begin
      cross_sum <= cross_new;
      if (prod.pos1) begin
        side0 <= d_pc;
      end
      if (prod.pos2) begin
        side1 <= d_pc;
        side2 <= d_fc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (prod_ready) begin
      v3 <= prod.valid;
    end
    if (mv2) begin
      last3  <= prod.last;
      clear3 <= prod.clear;
      rect3  <= rect;
      cnt3   <= prod.cnt;
      cross3 <= cross_new;
      close3 <= close_term;
    end
  end

  // closing term, saturation and magnitude side by side
  assign c_ext   = {cross3[CROSS_W-1], cross3};
  assign t_ext   = {{(SUM_W-TERM_W){close3[TERM_W-1]}}, close3};
  assign tot     = c_ext + t_ext;
  assign tot_neg = ~c_ext + ~t_ext + SUM_W'(2);

  always_comb begin
    if (tot[SUM_W-1] != tot[SUM_W-2]) begin
      area = tot[SUM_W-1] ? CROSS_MIN : CROSS_MAX;
    end else if (tot[SUM_W-2]) begin
      area = tot_neg[AREA_W-1:0];
    end else begin
      area = tot[AREA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_st.valid <= 1'b0;
    end else if (rdy4) begin
      area_st.valid <= v3;
    end
    if (v3 && rdy4) begin
      area_st.last    <= last3;
      area_st.clear   <= clear3;
      area_st.is_rect <= rect3;
      area_st.cnt     <= cnt3;
      area_st.area    <= area;
    end
  end

endmodule

### design/pas_aggregate.sv
module pas_aggregate (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pas_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  pas_pkg::area_stage_t              area_st,
  output logic                              area_ready,
  output logic                              res_valid,
  input  logic                              res_ready,
  output pas_pkg::result_t                  res
);
  import pas_pkg::*;

  localparam logic [AGG_W-1:0]  AGG_MAX  = {AGG_W{1'b1}};
  localparam logic [PCNT_W-1:0] PCNT_MAX = {PCNT_W{1'b1}};

  logic [MODE_W-1:0]   query_mode;
  logic [TARGET_W-1:0] target_vertices;
  logic [AGG_W-1:0]    aggregate_reg, aggregate_reg_next;
  logic [PCNT_W-1:0]   polygon_counter, polygon_counter_next;
  logic                agg_seen, agg_seen_next;

  logic                adv;
  logic [AGG_W-1:0]    agg_base;
  logic [PCNT_W-1:0]   pcnt_base;
  logic                seen_base;
  logic                match, even, on_target;
  agg_kind_t           kind;
  logic                use_cnt;
  logic [AGG_W-1:0]    val, addend;
  logic [AGG_W:0]      sum;
  logic [AGG_W-1:0]    sum_sat;

  assign area_ready = !area_st.last || !res_valid || res_ready;
  assign adv        = area_st.valid && area_ready;

  assign agg_base  = area_st.clear ? '0 : aggregate_reg;
  assign pcnt_base = area_st.clear ? '0 : polygon_counter;
  assign seen_base = area_st.clear ? 1'b0 : agg_seen;

  assign even      = !area_st.cnt[0];
  assign on_target = (area_st.cnt == target_vertices);

  always_comb begin
    match   = 1'b0;
    kind    = KIND_NONE;
    use_cnt = 1'b0;
    case (query_mode)
      MODE_SUM_EVEN: begin
        match = even;
        kind  = KIND_SUM;
      end
      MODE_SUM_ODD: begin
        match = !even;
        kind  = KIND_SUM;
      end
      MODE_SUM_ALL: begin
        match = 1'b1;
        kind  = KIND_SUM;
      end
      MODE_SUM_TARGET: begin
        match = on_target;
        kind  = KIND_SUM;
      end
      MODE_MAX_AREA: begin
        match = 1'b1;
        kind  = KIND_MAX;
      end
      MODE_MIN_AREA: begin
        match = 1'b1;
        kind  = KIND_MIN;
      end
      MODE_MAX_VERT: begin
        match   = 1'b1;
        kind    = KIND_MAX;
        use_cnt = 1'b1;
      end
      MODE_MIN_VERT: begin
        match   = 1'b1;
        kind    = KIND_MIN;
        use_cnt = 1'b1;
      end
      MODE_CNT_EVEN: begin
        match = even;
        kind  = KIND_COUNT;
      end
      MODE_CNT_ODD: begin
        match = !even;
        kind  = KIND_COUNT;
      end
      MODE_CNT_TARGET: begin
        match = on_target;
        kind  = KIND_COUNT;
      end
      MODE_CNT_RECT: begin
        match = area_st.is_rect;
        kind  = KIND_COUNT;
      end
      default: begin
        match = 1'b0;
        kind  = KIND_NONE;
      end
    endcase
  end

  assign val     = use_cnt ? AGG_W'(area_st.cnt) : AGG_W'(area_st.area);
  assign addend  = (kind == KIND_COUNT) ? AGG_W'(1) : val;
  assign sum     = {1'b0, agg_base} + {1'b0, addend};
  assign sum_sat = sum[AGG_W] ? AGG_MAX : sum[AGG_W-1:0];

  always_comb begin
    aggregate_reg_next   = agg_base;
    polygon_counter_next = pcnt_base;
    agg_seen_next        = seen_base;
    if (area_st.last) begin
      if (match) begin
        case (kind) inside
          KIND_SUM, KIND_COUNT: aggregate_reg_next = sum_sat;
          KIND_MAX: if (!seen_base || val > agg_base) aggregate_reg_next = val;
          KIND_MIN: if (!seen_base || val < agg_base) aggregate_reg_next = val;
          default:  aggregate_reg_next = agg_base;
        endcase
        agg_seen_next = 1'b1;
      end
      if (pcnt_base != PCNT_MAX) begin
        polygon_counter_next = pcnt_base + PCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_mode      <= QUERY_MODE_RESET;
      target_vertices <= TARGET_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_QUERY_MODE: query_mode      <= cfg_data[MODE_W-1:0];
        CFG_TARGET:     target_vertices <= cfg_data[TARGET_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      aggregate_reg   <= '0;
      polygon_counter <= '0;
      agg_seen        <= 1'b0;
    end else if (adv) begin
      aggregate_reg   <= aggregate_reg_next;
      polygon_counter <= polygon_counter_next;
      agg_seen        <= agg_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && area_st.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (adv && area_st.last) begin
      res.pad             <= '0;
      res.aggregate_valid <= agg_seen_next;
      res.polygons_seen   <= polygon_counter_next;
      res.aggregate_value <= aggregate_reg_next;
      res.matches_filter  <= match;
      res.is_rect         <= area_st.is_rect;
      res.vertex_total    <= area_st.cnt;
      res.twice_area      <= area_st.area;
    end
  end

endmodule

### tb/polygon_area_checker.sv
module polygon_area_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [pas_pkg::IN_TDATA_W-1:0]  s_tdata,   // coord_x, coord_y
  input  logic                            s_tlast,   // last_vertex
  input  logic                            s_tuser,   // clear_set
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // twice_area, vertex_total, is_rect, matches_filter, aggregate_value,
  // polygons_seen, aggregate_valid, zero pad
  input  logic [pas_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [pas_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              outstanding,
  output int                              vertices_in,
  output int                              polygons_out
);
  timeunit 1ns;
  timeprecision 1ps;
  import pas_pkg::*;

  localparam longint CROSS_HI = 64'sd1099511627775;
  localparam longint CROSS_LO = -64'sd1099511627776;
  localparam longint unsigned AGG_CAP = 64'hFFFF_FFFF_FFFF;
  localparam int PRINT_CAP = 40;

  // block state as the checker tracks it
  longint            fx, fy, sx, sy, px, py;
  longint            cross_acc;
  int unsigned       vtx_count;
  longint            side_len [3];
  longint unsigned   agg_acc;
  logic [PCNT_W-1:0] poly_count;
  logic              agg_live;
  logic [MODE_W-1:0]   query_mode;
  logic [TARGET_W-1:0] target_count;

  result_t closed_polygons [$];
  int      fail_count;
  int      vtx_total;
  int      poly_total;

  function automatic longint sq_dist(longint ax, longint ay, longint bx, longint by);
    longint dx, dy;
    dx = ax - bx;
    dy = ay - by;
    return dx * dx + dy * dy;
  endfunction

  function automatic longint clamp_cross(longint s);
    if (s > CROSS_HI) return CROSS_HI;
    if (s < CROSS_LO) return CROSS_LO;
    return s;
  endfunction

  function automatic longint unsigned sat48(longint unsigned s);
    return (s > AGG_CAP) ? AGG_CAP : s;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  task automatic track_vertex(input logic [IN_TDATA_W-1:0] data, input logic last,
                              input logic clear);
    longint          x, y, mag;
    int unsigned     idx, cnt;
    logic            rect, hit;
    agg_kind_t       kind;
    longint unsigned val;
    result_t         r;
    x = longint'($signed(data[COORD_WIDTH-1:0]));
    y = longint'($signed(data[IN_TDATA_W-1:COORD_WIDTH]));
    rect = 1'b0;
    hit = 1'b0;
    kind = KIND_NONE;
    val = 0;
    idx = vtx_count;
    vtx_total++;
    if (clear) begin
      agg_acc = 0;
      poly_count = '0;
      agg_live = 1'b0;
    end
    if (idx == 0) begin
      fx = x;
      fy = y;
      cross_acc = 0;
    end else begin
      cross_acc = clamp_cross(cross_acc + px * y - py * x);
      if (idx == 1) begin
        sx = x;
        sy = y;
        side_len[0] = sq_dist(px, py, x, y);
      end else if (idx == 2) begin
        side_len[1] = sq_dist(px, py, x, y);
        side_len[2] = sq_dist(fx, fy, x, y);
      end else if (idx == 3 && last) begin
        rect = side_len[0] == sq_dist(px, py, x, y) &&
               side_len[1] == sq_dist(x, y, fx, fy) &&
               side_len[2] == sq_dist(sx, sy, x, y);
      end
    end
    px = x;
    py = y;
    cnt = (idx < MAX_VERTICES) ? idx + 1 : MAX_VERTICES;
    if (!last) begin
      vtx_count = cnt;
      return;
    end

    cross_acc = clamp_cross(cross_acc + x * fy - fx * y);
    mag = (cross_acc < 0) ? -cross_acc : cross_acc;
    vtx_count = 0;

    case (query_mode)
      MODE_SUM_EVEN:   begin hit = ~cnt[0]; kind = KIND_SUM; val = mag; end
      MODE_SUM_ODD:    begin hit = cnt[0]; kind = KIND_SUM; val = mag; end
      MODE_SUM_ALL:    begin hit = 1'b1; kind = KIND_SUM; val = mag; end
      MODE_SUM_TARGET: begin hit = (cnt == target_count); kind = KIND_SUM; val = mag; end
      MODE_MAX_AREA:   begin hit = 1'b1; kind = KIND_MAX; val = mag; end
      MODE_MIN_AREA:   begin hit = 1'b1; kind = KIND_MIN; val = mag; end
      MODE_MAX_VERT:   begin hit = 1'b1; kind = KIND_MAX; val = cnt; end
      MODE_MIN_VERT:   begin hit = 1'b1; kind = KIND_MIN; val = cnt; end
      MODE_CNT_EVEN:   begin hit = ~cnt[0]; kind = KIND_COUNT; end
      MODE_CNT_ODD:    begin hit = cnt[0]; kind = KIND_COUNT; end
      MODE_CNT_TARGET: begin hit = (cnt == target_count); kind = KIND_COUNT; end
      MODE_CNT_RECT:   begin hit = rect; kind = KIND_COUNT; end
      default: ;
    endcase

    if (hit) begin
      case (kind)
        KIND_SUM:   agg_acc = sat48(agg_acc + val);
        KIND_COUNT: agg_acc = sat48(agg_acc + 1);
        KIND_MAX:   if (!agg_live || val > agg_acc) agg_acc = val;
        KIND_MIN:   if (!agg_live || val < agg_acc) agg_acc = val;
        default: ;
      endcase
      agg_live = 1'b1;
    end
    if (poly_count != {PCNT_W{1'b1}}) poly_count++;

    r = '0;
    r.twice_area      = mag[AREA_W-1:0];
    r.vertex_total    = cnt[CNT_W-1:0];
    r.is_rect         = rect;
    r.matches_filter  = hit;
    r.aggregate_value = agg_acc[AGG_W-1:0];
    r.polygons_seen   = poly_count;
    r.aggregate_valid = agg_live;
    closed_polygons.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t seen, want;
    if (rst) begin
      fx = 0; fy = 0; sx = 0; sy = 0; px = 0; py = 0;
      cross_acc = 0;
      vtx_count = 0;
      side_len[0] = 0; side_len[1] = 0; side_len[2] = 0;
      agg_acc = 0;
      poly_count = '0;
      agg_live = 1'b0;
      query_mode = QUERY_MODE_RESET;
      target_count = TARGET_RESET;
      closed_polygons.delete();
      fail_count = 0;
      vtx_total = 0;
      poly_total = 0;
    end else begin
      // results first, so a stray result never pairs with a polygon closing now
      if (m_tvalid && m_tready) begin
        seen = m_tdata;
        if (closed_polygons.size() == 0) begin
          report("result with no polygon closed, twice_area", seen.twice_area, 0);
        end else begin
          want = closed_polygons.pop_front();
          poly_total++;
          if (seen.twice_area !== want.twice_area)
            report("twice_area", seen.twice_area, want.twice_area);
          if (seen.vertex_total !== want.vertex_total)
            report("vertex_total", seen.vertex_total, want.vertex_total);
          if (seen.is_rect !== want.is_rect)
            report("is_rect", seen.is_rect, want.is_rect);
          if (seen.matches_filter !== want.matches_filter)
            report("matches_filter", seen.matches_filter, want.matches_filter);
          if (seen.aggregate_value !== want.aggregate_value)
            report("aggregate_value", seen.aggregate_value, want.aggregate_value);
          if (seen.polygons_seen !== want.polygons_seen)
            report("polygons_seen", seen.polygons_seen, want.polygons_seen);
          if (seen.aggregate_valid !== want.aggregate_valid)
            report("aggregate_valid", seen.aggregate_valid, want.aggregate_valid);
        end
      end
      if (s_tvalid && s_tready)
        track_vertex(s_tdata, s_tlast, s_tuser);
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUERY_MODE: query_mode = cfg_data[MODE_W-1:0];
          CFG_TARGET:     target_count = cfg_data[TARGET_W-1:0];
          default: ;
        endcase
      end
    end
    mismatches   <= fail_count;
    outstanding  <= closed_polygons.size();
    vertices_in  <= vtx_total;
    polygons_out <= poly_total;
  end

endmodule

### tb/tb_polygon_area_stats_top.sv
module tb_polygon_area_stats_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pas_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 25;
  localparam int SOAK_POLYGONS = 2;
  localparam int SOAK_WINDING = 540;
  localparam logic [MODE_W-1:0] MODE_SPARE     = 4'd13;
  localparam logic [MODE_W-1:0] MODE_LAST_CODE = 4'd15;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;    // coord_x, coord_y
  logic                   s_tlast = 1'b0;  // last_vertex
  logic                   s_tuser = 1'b0;  // clear_set
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // twice_area, vertex_total, is_rect, matches_filter, aggregate_value,
  // polygons_seen, aggregate_valid, zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int mismatches, outstanding, vertices_in, polygons_out;

  bit                    steady = 1'b0;
  int                    clear_pct = 4;
  int                    phase_items;
  int                    reg_writes = 0;
  int                    idle_cycles = 0;
  logic [IN_TDATA_W-1:0] outline [$];  // {y, x} of the polygon being built
  logic [MODE_W-1:0]     set_mode;
  logic [TARGET_W-1:0]   set_target;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  polygon_area_stats_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  polygon_area_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding),
    .vertices_in(vertices_in), .polygons_out(polygons_out)
  );

  always @(posedge clk) m_tready <= steady || ($urandom_range(99) >= 28);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d polygons still owed", STALL_LIMIT, outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [15:0] pick_coord();
    int unsigned r;
    r = $urandom_range(7);
    if (r < 4) return 16'($urandom);
    if (r < 6) return 16'($urandom_range(40)) - 16'd20;
    if (r == 6) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    return $urandom_range(1) ? 16'hFFFF : 16'h0000;
  endfunction

  function automatic longint any_coord();
    return longint'($signed(pick_coord()));
  endfunction

  function automatic longint span(int unsigned half);
    return longint'($urandom_range(2 * half)) - longint'(half);
  endfunction

  task automatic add_vertex(input longint x, input longint y);
    outline.push_back({16'(y), 16'(x)});
  endtask

  // laps around the corners of the coordinate range, all cross terms one sign
  task automatic wind(input int n, input int unsigned jitter);
    int c;
    for (int i = 0; i < n; i++) begin
      c = i % 4;
      add_vertex((c == 0 || c == 3) ? 32767 - longint'($urandom_range(jitter))
                                    : -32768 + longint'($urandom_range(jitter)),
                 (c < 2) ? 32767 - longint'($urandom_range(jitter))
                         : -32768 + longint'($urandom_range(jitter)));
    end
  endtask

  task automatic send_vertex(input logic [15:0] x, input logic [15:0] y, input logic last,
                             input logic clear);
    while (!steady && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    s_tlast  <= last;
    s_tuser  <= clear;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_outline(input bit clear_first, input bit backwards);
    int n;
    logic [IN_TDATA_W-1:0] v;
    bit clr;
    n = outline.size();
    for (int i = 0; i < n; i++) begin
      v = backwards ? outline[n - 1 - i] : outline[i];
      clr = (i == 0 && clear_first) || ($urandom_range(99) < clear_pct);
      send_vertex(v[15:0], v[31:16], i == n - 1, clr);
      phase_items++;
    end
    outline.delete();
  endtask

  task automatic build_random_polygon();
    int unsigned pick;
    int n;
    longint x1, y1, x2, y2, ax, ay, bx, by, k;
    pick = $urandom_range(99);
    if (pick < 12) begin
      x1 = any_coord(); y1 = any_coord(); x2 = any_coord(); y2 = any_coord();
      add_vertex(x1, y1); add_vertex(x2, y1); add_vertex(x2, y2); add_vertex(x1, y2);
    end else if (pick < 32) begin
      // tilted rectangle, or a parallelogram with a random second side
      x1 = span(1000); y1 = span(1000);
      ax = span(150); ay = span(150);
      if (pick < 22) begin
        k = 1 + longint'($urandom_range(2));
        bx = -k * ay; by = k * ax;
      end else begin
        bx = span(200); by = span(200);
      end
      add_vertex(x1, y1);
      add_vertex(x1 + ax, y1 + ay);
      add_vertex(x1 + ax + bx, y1 + ay + by);
      add_vertex(x1 + bx, y1 + by);
    end else begin
      n = (pick < 45) ? 1 + $urandom_range(2) : 3 + $urandom_range(7);
      for (int i = 0; i < n; i++) add_vertex(any_coord(), any_coord());
    end
  endtask

  task automatic write_cfg(input logic [MODE_W-1:0] mode, input logic [TARGET_W-1:0] target);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_QUERY_MODE;
    cfg_data  <= {{(CFG_DATA_W - MODE_W){1'b0}}, mode};
    @(posedge clk);
    cfg_index <= CFG_TARGET;
    cfg_data  <= target;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes += 2;
  endtask

  // idle the input and wait until every closed polygon has been reported
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed shapes under the reset settings
    add_vertex(-32768, 32767);
    send_outline(1'b1, 1'b0);
    add_vertex(32767, 32767); add_vertex(-32768, -32768);
    send_outline(1'b0, 1'b0);
    add_vertex(-32768, -32768); add_vertex(32767, -32768);
    add_vertex(32767, 32767); add_vertex(-32768, 32767);
    send_outline(1'b0, 1'b0);
    add_vertex(0, 0); add_vertex(3, 4); add_vertex(-1, 7); add_vertex(-4, 3);
    send_outline(1'b0, 1'b1);
    add_vertex(0, 0); add_vertex(5, 0); add_vertex(7, 3); add_vertex(2, 3);
    send_outline(1'b0, 1'b0);
    add_vertex(0, 0); add_vertex(-1, 0); add_vertex(0, -1);
    send_outline(1'b0, 1'b0);
    // clear arriving partway through a polygon
    send_vertex(16'd0, 16'd0, 1'b0, 1'b0);
    send_vertex(16'd10, 16'd0, 1'b0, 1'b0);
    send_vertex(16'd12, 16'd8, 1'b0, 1'b1);
    send_vertex(16'd5, 16'd12, 1'b0, 1'b0);
    send_vertex(-16'sd2, 16'd8, 1'b1, 1'b0);
    drain();

    for (int p = 0; p < 16; p++) begin
      case (p)
        0:  begin set_mode = MODE_SUM_EVEN;   set_target = 9'd4;   end
        1:  begin set_mode = MODE_SUM_ODD;    set_target = 9'd0;   end
        2:  begin set_mode = MODE_SUM_TARGET; set_target = 9'd4;   end
        3:  begin set_mode = MODE_MAX_AREA;   set_target = 9'd511; end
        4:  begin set_mode = MODE_MIN_AREA;   set_target = 9'd3;   end
        5:  begin set_mode = MODE_MAX_VERT;   set_target = 9'd256; end
        6:  begin set_mode = MODE_MIN_VERT;   set_target = 9'd2;   end
        7:  begin set_mode = MODE_CNT_EVEN;   set_target = 9'd5;   end
        8:  begin set_mode = MODE_CNT_ODD;    set_target = 9'd1;   end
        9:  begin set_mode = MODE_CNT_TARGET; set_target = 9'd3;   end
        10: begin set_mode = MODE_CNT_RECT;   set_target = 9'd4;   end
        11: begin set_mode = MODE_SPARE;      set_target = 9'd256; end
        12: begin set_mode = MODE_LAST_CODE;  set_target = 9'd0;   end
        13: begin set_mode = MODE_SUM_TARGET; set_target = 9'd256; end
        14: begin set_mode = MODE_CNT_TARGET; set_target = 9'd0;   end
        default: begin set_mode = MODE_SUM_ALL; set_target = 9'd511; end
      endcase
      write_cfg(set_mode, set_target);
      steady = (p == 6 || p == 7);
      phase_items = 0;
      build_random_polygon();
      send_outline(1'($urandom_range(1)), 1'($urandom_range(1)));
      while (phase_items < PHASE_ITEMS) begin
        build_random_polygon();
        send_outline(1'b0, 1'($urandom_range(1)));
      end
      drain();
    end

    // saturate the cross sum both ways and the vertex count
    steady = 1'b1;
    clear_pct = 0;
    write_cfg(MODE_SUM_ALL, TARGET_RESET);
    for (int i = 0; i < SOAK_POLYGONS; i++) begin
      wind(SOAK_WINDING, 0);
      send_outline(i == 0, i == 1);
    end
    drain();

    $display("checked %0d polygons from %0d vertex transfers", polygons_out, vertices_in);
    $display("%0d register writes over all query modes, saturation soak included", reg_writes);
    if (mismatches == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/pas_pkg.sv
design/pas_vertex.sv
design/pas_cross.sv
design/pas_aggregate.sv
design/polygon_area_stats_top.sv
tb/polygon_area_checker.sv
tb/tb_polygon_area_stats_top.sv
